FILE: rtl/core/tccw_pkg.sv
// tccw_pkg: shared types and constants of the text console cell writer
// request and response payload structs, control byte codes, cell defaults
// no dependencies
`default_nettype none

package tccw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] CH_BS        = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] DEFAULT_ATTR = 8'd7;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
    logic       end_of_text;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tccw_in_t;

  typedef struct packed {
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic       scrolled;
    logic       span_valid;
    logic [4:0] span_first;
    logic [4:0] span_last;
    logic       span_full;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } tccw_out_t;

  typedef struct packed {
    logic capture;
    logic init_step;
    logic exec_put;
    logic rd_issue;
    logic rd_done;
    logic clr_step;
    logic load_live;
    logic load_held;
  } tccw_cmd_t;

  typedef struct packed {
    logic in_read;
    logic scroll;
    logic out_free;
    logic init_last;
    logic clr_last;
  } tccw_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/tccw_in_if.sv
// tccw_in_if: request channel of the text console cell writer
// valid/ready handshake with a tccw_in_t payload, depends on tccw_pkg
`default_nettype none

interface tccw_in_if import tccw_pkg::*; ();
  logic     valid;
  logic     ready;
  tccw_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tccw_out_if.sv
// tccw_out_if: response channel of the text console cell writer
// valid/ready handshake with a tccw_out_t payload, depends on tccw_pkg
`default_nettype none

interface tccw_out_if import tccw_pkg::*; ();
  logic      valid;
  logic      ready;
  tccw_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tccw_ram.sv
// tccw_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none

module tccw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/tccw_ctrl.sv
// tccw_ctrl: sequencer of the text console cell writer
// issues datapath commands from status, depends on tccw_pkg
`default_nettype none

module tccw_ctrl import tccw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  tccw_sts_t sts_i,
  output tccw_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_CLR,
    ST_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    pend_d  = pend_q;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.in_read) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_RDWAIT;
        end else begin
          cmd_o.exec_put  = 1'b1;
          cmd_o.load_live = sts_i.out_free;
          pend_d          = !sts_i.out_free;
          if (sts_i.scroll) begin
            state_d = ST_CLR;
          end else if (sts_i.out_free) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_RDWAIT: begin
        cmd_o.rd_done   = 1'b1;
        cmd_o.load_live = sts_i.out_free;
        state_d         = sts_i.out_free ? ST_IDLE : ST_HOLD;
      end
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = pend_q ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.load_held = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/tccw_dp.sv
// tccw_dp: datapath of the text console cell writer
// cursor, row origin, dirty span tracker, cell store addressing, response register
// depends on tccw_pkg, drives the cell ram ports
`default_nettype none

module tccw_dp import tccw_pkg::*; #(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF,
  localparam int unsigned DEPTH  = ROWS * COLUMNS,
  localparam int unsigned ADDR_W = $clog2(DEPTH),
  localparam int unsigned ROW_W  = $clog2(ROWS),
  localparam int unsigned COL_W  = $clog2(COLUMNS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tccw_in_t          req_data_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  tccw_cmd_t         cmd_i,
  output tccw_sts_t         sts_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output tccw_out_t         rsp_data_o,
  output logic              ram_we_o,
  output logic              ram_re_o,
  output logic [ADDR_W-1:0] ram_addr_o,
  output logic [15:0]       ram_wdata_o,
  input  logic [15:0]       ram_rdata_i
);

  typedef struct packed {
    logic [ROW_W-1:0] lo;
    logic [ROW_W-1:0] hi;
    logic             empty;
    logic             all;
  } trk_t;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam trk_t TRK_CLEAR = '{lo: '0, hi: '0, empty: 1'b1, all: 1'b0};
  localparam trk_t TRK_FULL  = '{lo: '0, hi: LAST_ROW, empty: 1'b0, all: 1'b1};

  function automatic trk_t mark(trk_t t, logic [ROW_W-1:0] r);
    trk_t m;
    m = t;
    if (!t.all) begin
      if (t.empty) begin
        m.lo    = r;
        m.hi    = r;
        m.empty = 1'b0;
      end else begin
        if (r < t.lo) m.lo = r;
        if (r > t.hi) m.hi = r;
      end
    end
    return m;
  endfunction

  tccw_in_t         in_q;
  logic [ROW_W-1:0] cur_row_q;
  logic [COL_W-1:0] cur_col_q;
  logic [ROW_W-1:0] top_q;
  trk_t             trk_q;
  logic [7:0]       attr_q;
  logic [ADDR_W-1:0] cnt_q;
  logic [ADDR_W-1:0] clr_base_q;
  logic [7:0]       clr_attr_q;
  logic             oor_q;
  tccw_out_t        res_q;
  tccw_out_t        out_q;
  logic             out_valid_q;

  logic [ROW_W-1:0] p_row, wr_row, a_row, a_phys;
  logic [COL_W-1:0] p_col, wr_col, a_col;
  logic [ROW_W:0]   phys_sum;
  logic [7:0]       wr_chr;
  logic             wr_en, mark_en, do_lf, scroll;
  trk_t             trk1, trk2, trk_d;
  tccw_out_t        put_res, read_res, live_res;
  logic [ADDR_W-1:0] calc_addr;
  logic             rd_in_range;

  // cursor step for one put byte
  always_comb begin
    p_row   = cur_row_q;
    p_col   = cur_col_q;
    wr_row  = cur_row_q;
    wr_col  = cur_col_q;
    wr_chr  = CH_SPACE;
    wr_en   = 1'b0;
    mark_en = 1'b0;
    do_lf   = 1'b0;
    scroll  = 1'b0;
    priority if (in_q.char_code == CH_CR) begin
      p_col = '0;
    end else if (in_q.char_code == CH_LF) begin
      do_lf = 1'b1;
    end else if (in_q.char_code == CH_BS) begin
      if (cur_col_q != '0) begin
        wr_col = cur_col_q - 1'b1;
      end else if (cur_row_q != '0) begin
        wr_row = cur_row_q - 1'b1;
        wr_col = LAST_COL;
      end
      wr_en   = 1'b1;
      mark_en = 1'b1;
      p_row   = wr_row;
      p_col   = wr_col;
    end else begin
      wr_chr  = in_q.char_code;
      wr_en   = 1'b1;
      mark_en = 1'b1;
      if (cur_col_q == LAST_COL) begin
        do_lf = 1'b1;
      end else begin
        p_col = cur_col_q + 1'b1;
      end
    end
    if (do_lf) begin
      p_col = '0;
      if (cur_row_q == LAST_ROW) begin
        scroll = 1'b1;
        p_row  = LAST_ROW;
      end else begin
        p_row = cur_row_q + 1'b1;
      end
    end
  end

  // dirty span tracking
  always_comb begin
    trk1 = mark_en ? mark(trk_q, wr_row) : trk_q;
    if (scroll) begin
      trk1 = TRK_FULL;
    end
    trk2  = mark(trk1, p_row);
    trk_d = in_q.end_of_text ? TRK_CLEAR : trk1;
  end

  always_comb begin
    put_res                = '0;
    put_res.cursor_row_out = 5'(p_row);
    put_res.cursor_col_out = 7'(p_col);
    put_res.scrolled       = scroll;
    put_res.span_valid     = in_q.end_of_text;
    if (in_q.end_of_text) begin
      put_res.span_first = 5'(trk2.lo);
      put_res.span_last  = 5'(trk2.hi);
      put_res.span_full  = trk2.all;
    end
  end

  always_comb begin
    read_res                = '0;
    read_res.cursor_row_out = 5'(cur_row_q);
    read_res.cursor_col_out = 7'(cur_col_q);
    if (!oor_q) begin
      read_res.cell_char = ram_rdata_i[7:0];
      read_res.cell_attr = ram_rdata_i[15:8];
    end
  end

  assign live_res = cmd_i.rd_done ? read_res : put_res;

  // logical row to physical row through the scrolling origin
  assign rd_in_range = (32'(in_q.read_row) < 32'(ROWS)) && (32'(in_q.read_col) < 32'(COLUMNS));
  assign a_row    = (in_q.mode == MODE_READ) ? ROW_W'(in_q.read_row) : wr_row;
  assign a_col    = (in_q.mode == MODE_READ) ? COL_W'(in_q.read_col) : wr_col;
  assign phys_sum = {1'b0, a_row} + {1'b0, top_q};
  assign a_phys   = (phys_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(phys_sum - (ROW_W + 1)'(ROWS))
                                                     : ROW_W'(phys_sum);
  assign calc_addr = ADDR_W'(a_phys) * ADDR_W'(COLUMNS) + ADDR_W'(a_col);

  always_comb begin
    ram_we_o    = 1'b0;
    ram_re_o    = cmd_i.rd_issue;
    ram_addr_o  = calc_addr;
    ram_wdata_o = {attr_q, wr_chr};
    priority if (cmd_i.init_step) begin
      ram_we_o    = 1'b1;
      ram_addr_o  = cnt_q;
      ram_wdata_o = {DEFAULT_ATTR, CH_SPACE};
    end else if (cmd_i.clr_step) begin
      ram_we_o    = 1'b1;
      ram_addr_o  = clr_base_q + cnt_q;
      ram_wdata_o = {clr_attr_q, CH_SPACE};
    end else begin
      ram_we_o = cmd_i.exec_put & wr_en;
    end
  end

  assign sts_o.in_read   = (in_q.mode == MODE_READ);
  assign sts_o.scroll    = scroll;
  assign sts_o.out_free  = !out_valid_q || rsp_ready_i;
  assign sts_o.init_last = (cnt_q == ADDR_W'(DEPTH - 1));
  assign sts_o.clr_last  = (cnt_q == ADDR_W'(COLUMNS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= req_data_i;
    end
    if (cmd_i.exec_put) begin
      res_q      <= put_res;
      clr_base_q <= ADDR_W'(top_q) * ADDR_W'(COLUMNS);
      clr_attr_q <= attr_q;
    end
    if (cmd_i.rd_issue) begin
      oor_q <= !rd_in_range;
    end
    if (cmd_i.rd_done) begin
      res_q <= read_res;
    end
    if (cmd_i.load_live) begin
      out_q <= live_res;
    end else if (cmd_i.load_held) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      top_q       <= '0;
      trk_q       <= TRK_CLEAR;
      attr_q      <= DEFAULT_ATTR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (cmd_i.exec_put) begin
        cur_row_q <= p_row;
        cur_col_q <= p_col;
        trk_q     <= trk_d;
        if (scroll) begin
          top_q <= (top_q == LAST_ROW) ? '0 : top_q + 1'b1;
        end
      end
      if (cmd_i.init_step) begin
        cnt_q <= sts_o.init_last ? '0 : cnt_q + 1'b1;
      end else if (cmd_i.clr_step) begin
        cnt_q <= sts_o.clr_last ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.load_live || cmd_i.load_held) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/text_console_cell_writer.sv
// text_console_cell_writer: top level of the text console cell writer
// joins tccw_ctrl, tccw_dp and the cell store tccw_ram, depends on tccw_pkg and the channel interfaces
//
// Cells live in a ROWS*COLUMNS ram addressed through a row origin pointer, so a scroll moves
// the origin instead of copying rows. After reset the block sweeps the whole store to spaces
// with attribute 7 before it takes the first request. Requests are handled one at a time; a
// read goes through the registered ram read, and a line feed past the bottom row adds a
// clear pass in which the ram's single port blanks the new last row with the current
// attribute. The response sits in an output register, so a new request is taken while the
// previous response waits.
`default_nettype none

module text_console_cell_writer import tccw_pkg::*; #(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tccw_in_if.sink     req_i,
  tccw_out_if.source  rsp_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam int unsigned DEPTH  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  tccw_cmd_t         cmd;
  tccw_sts_t         sts;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [15:0]       ram_wdata, ram_rdata;

  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tccw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_data_i  (req_i.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_data_o  (rsp_o.data),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  tccw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
